@@ rtl/wfba_pkg.sv @@
package wfba_pkg;

	// Default size of the managed memory, in allocation units
	localparam int MEM_UNITS_DEF = 512;

	// Request and result field widths
	localparam int SIZE_W = 10;
	localparam int ADDR_W = 9;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 10;

	// Stream data widths, rounded up to whole bytes
	localparam int IN_W        = SIZE_W + ADDR_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = STAT_W + ADDR_W + LEN_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Request kinds
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RESERVE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_DONE         = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT        = 2'd1;
	localparam logic [STAT_W-1:0] ST_RESERVE_FAIL = 2'd2;

	// Per-cycle control of the run tracker
	typedef struct packed {
		logic clear;     // start of a new request
		logic step;      // one map bit arrives
		logic unit_free; // that bit is a free unit
		logic close;     // end of map, acts as a used unit
	} trk_ctrl_t;

endpackage

@@ rtl/wfba_bitmap.sv @@
module wfba_bitmap import wfba_pkg::*; #(
	parameter int MEM_UNITS = MEM_UNITS_DEF,
	parameter int AW        = $clog2(MEM_UNITS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic mem [MEM_UNITS];

	// Single-port occupancy store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/wfba_run_tracker.sv @@
module wfba_run_tracker import wfba_pkg::*; #(
	parameter int AW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trk_ctrl_t         ctrl,
	input  logic [AW-1:0]     idx,
	input  logic [SIZE_W-1:0] size,
	output logic              found,
	output logic [AW-1:0]     best_start,
	output logic [AW:0]       best_len,
	output logic              used_seen
);

	localparam int CW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

	logic [AW-1:0] run_start_q;
	logic [AW:0]   run_len_q;
	logic [AW-1:0] best_start_q;
	logic [AW:0]   best_len_q;
	logic          found_q;
	logic          used_q;
	logic          end_run;
	logic          run_fits;

	// A run ends at a used unit or at the end of the map
	assign end_run  = ctrl.close || (ctrl.step && !ctrl.unit_free);
	// Shared compare: run qualifies and beats the best so far (lower start wins ties)
	assign run_fits = (run_len_q != '0) && (CW'(run_len_q) >= CW'(size)) &&
		(!found_q || (run_len_q > best_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q  <= '0;
			run_len_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			found_q      <= 1'b0;
			used_q       <= 1'b0;
		end else if (ctrl.clear) begin
			run_len_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
			found_q      <= 1'b0;
			used_q       <= 1'b0;
		end else begin
			if (ctrl.step && ctrl.unit_free) begin
				if (run_len_q == '0) begin
					run_start_q <= idx;
				end
				run_len_q <= run_len_q + 1'b1;
			end
			if (end_run) begin
				if (run_fits) begin
					found_q      <= 1'b1;
					best_start_q <= run_start_q;
					best_len_q   <= run_len_q;
				end
				run_len_q <= '0;
			end
			if (ctrl.step && !ctrl.unit_free) begin
				used_q <= 1'b1;
			end
		end
	end

	assign found      = found_q;
	assign best_start = best_start_q;
	assign best_len   = best_len_q;
	assign used_seen  = used_q;

endmodule

@@ rtl/worst_fit_bitmap_allocator.sv @@
// Allocate: the map is read one unit per cycle, then the grant is marked one unit per cycle;
//   on no-fit or zero size the result follows the map read with nothing marked.
// Reserve: the range is read, then marked unless it overlaps; out-of-range or zero size: no read.
// One request at a time; the next is taken the cycle after its result enters the output reg.
// Reset (arst_n low, asynchronous) clears control; a clearing pass then frees every unit
//   before the first request is taken.
module worst_fit_bitmap_allocator import wfba_pkg::*; #(
	parameter int MEM_UNITS = MEM_UNITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // req_size, req_address
	input  logic                   s_axis_tuser,  // op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, base_address, hole_length
);

	localparam int AW = $clog2(MEM_UNITS);
	localparam int BW = (AW + 1 > SIZE_W + 1) ? AW + 1 : SIZE_W + 1;
	localparam logic [AW-1:0] LAST_UNIT = AW'(MEM_UNITS - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_CLOSE  = 3'd4;
	localparam logic [2:0] S_EVAL   = 3'd5;
	localparam logic [2:0] S_MARK   = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	logic [2:0]        state_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     last_q;
	logic              op_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] mark_left_q;
	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_base_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              rd_pend_s1;
	logic [AW-1:0]     idx_s1;

	logic              req_op;
	logic [SIZE_W-1:0] req_size;
	logic [ADDR_W-1:0] req_address;
	logic              accept;
	logic [BW-1:0]     rsv_end;
	logic              rsv_out_of_range;

	logic              mem_we;
	logic              mem_re;
	logic              mem_wdata;
	logic              mem_rdata;

	trk_ctrl_t         trk_ctrl;
	logic              trk_found;
	logic [AW-1:0]     trk_best_start;
	logic [AW:0]       trk_best_len;
	logic              trk_used_seen;

	// Request unpacking
	assign req_op      = s_axis_tuser;
	assign req_size    = s_axis_tdata[SIZE_W-1:0];
	assign req_address = s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Reserve range check: end must not pass the last unit
	assign rsv_end          = BW'(req_address) + BW'(req_size);
	assign rsv_out_of_range = rsv_end > BW'(MEM_UNITS);

	// Bitmap port use per state
	always_comb begin
		mem_we    = (state_q == S_CLEAR) || (state_q == S_MARK);
		mem_wdata = (state_q == S_MARK);
		mem_re    = (state_q == S_SCAN);
	end

	wfba_bitmap #(
		.MEM_UNITS(MEM_UNITS),
		.AW(AW)
	) u_bitmap (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(ptr_q),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Tracker control from the read pipeline
	always_comb begin
		trk_ctrl.clear     = accept;
		trk_ctrl.step      = rd_pend_s1;
		trk_ctrl.unit_free = !mem_rdata;
		trk_ctrl.close     = (state_q == S_CLOSE);
	end

	wfba_run_tracker #(
		.AW(AW)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(trk_ctrl),
		.idx(idx_s1),
		.size(size_q),
		.found(trk_found),
		.best_start(trk_best_start),
		.best_len(trk_best_len),
		.used_seen(trk_used_seen)
	);

	// Read tag follows the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			idx_s1     <= '0;
		end else begin
			rd_pend_s1 <= (state_q == S_SCAN);
			idx_s1     <= ptr_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			last_q       <= '0;
			op_q         <= OP_ALLOC;
			size_q       <= '0;
			addr_q       <= '0;
			mark_left_q  <= '0;
			res_status_q <= ST_DONE;
			res_base_q   <= '0;
			res_len_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (ptr_q == LAST_UNIT) begin
						state_q <= S_IDLE;
					end
					ptr_q <= ptr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						op_q   <= req_op;
						size_q <= req_size;
						addr_q <= req_address;
						if (req_op == OP_ALLOC) begin
							ptr_q   <= '0;
							last_q  <= LAST_UNIT;
							state_q <= S_SCAN;
						end else if (rsv_out_of_range) begin
							res_status_q <= ST_RESERVE_FAIL;
							res_base_q   <= '0;
							res_len_q    <= '0;
							state_q      <= S_RESULT;
						end else if (req_size == '0) begin
							res_status_q <= ST_DONE;
							res_base_q   <= req_address;
							res_len_q    <= '0;
							state_q      <= S_RESULT;
						end else begin
							ptr_q   <= AW'(req_address);
							last_q  <= AW'(rsv_end - 1'b1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (ptr_q == last_q) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					mark_left_q <= size_q;
					if (op_q == OP_ALLOC) begin
						if (!trk_found) begin
							res_status_q <= ST_NOFIT;
							res_base_q   <= '0;
							res_len_q    <= '0;
							state_q      <= S_RESULT;
						end else begin
							res_status_q <= ST_DONE;
							res_base_q   <= ADDR_W'(trk_best_start);
							res_len_q    <= LEN_W'(trk_best_len);
							ptr_q        <= trk_best_start;
							state_q      <= (size_q == '0) ? S_RESULT : S_MARK;
						end
					end else if (trk_used_seen) begin
						res_status_q <= ST_RESERVE_FAIL;
						res_base_q   <= '0;
						res_len_q    <= '0;
						state_q      <= S_RESULT;
					end else begin
						res_status_q <= ST_DONE;
						res_base_q   <= addr_q;
						res_len_q    <= '0;
						ptr_q        <= AW'(addr_q);
						state_q      <= S_MARK;
					end
				end
				S_MARK: begin
					if (mark_left_q == SIZE_W'(1)) begin
						state_q <= S_RESULT;
					end else begin
						ptr_q       <= ptr_q + 1'b1;
						mark_left_q <= mark_left_q - 1'b1;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESULT) && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESULT) && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {res_len_q, res_base_q, res_status_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

endmodule

@@ rtl/wfba_checker.sv @@
module wfba_checker import wfba_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [STAT_W-1:0] st;
	logic [ADDR_W-1:0] base;
	logic [LEN_W-1:0]  len;

	assign st   = m_axis_tdata[STAT_W-1:0];
	assign base = m_axis_tdata[STAT_W+ADDR_W-1:STAT_W];
	assign len  = m_axis_tdata[OUT_W-1:STAT_W+ADDR_W];

	// A taken request keeps the block busy for at least the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while previous one still in work");

	// Only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (st == ST_DONE) || (st == ST_NOFIT) || (st == ST_RESERVE_FAIL))
		else $error("undefined status code");

	// A failed request reports zero base and zero hole length
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st != ST_DONE) |-> (base == '0) && (len == '0))
		else $error("failed request carries nonzero fields");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind worst_fit_bitmap_allocator wfba_checker u_wfba_checker (.*);

@@ dv/wfba_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams, keeps a shadow occupancy map and checks every result
module wfba_tb_checker import wfba_pkg::*; #(
	parameter int MEM_UNITS = MEM_UNITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // req_size, req_address
	input  logic                   s_axis_tuser,  // op
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // status, base_address, hole_length
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  hole;
	} grant_t;

	logic [MEM_UNITS-1:0] occ_map = '0;
	grant_t               grant_q[$];
	int                   bad = 0;

	assign mismatches = bad;

	// Works out the grant for one request and updates the shadow map
	function automatic grant_t place_request(logic op, logic [SIZE_W-1:0] size,
			logic [ADDR_W-1:0] addr);
		grant_t g;
		int     i, run_start, run_len, best_start, best_len;
		bit     found, unit_free, clash;
		g = '0;
		g.status = ST_DONE;
		if (op == OP_ALLOC) begin
			run_start = 0;
			run_len = 0;
			best_start = 0;
			best_len = 0;
			found = 1'b0;
			// one position past the end closes the last run
			for (i = 0; i <= MEM_UNITS; i++) begin
				unit_free = (i < MEM_UNITS) && !occ_map[i];
				if (unit_free) begin
					if (run_len == 0)
						run_start = i;
					run_len++;
				end else begin
					if (run_len > 0 && run_len >= size && (!found || run_len > best_len)) begin
						found = 1'b1;
						best_start = run_start;
						best_len = run_len;
					end
					run_len = 0;
				end
			end
			if (!found) begin
				g.status = ST_NOFIT;
			end else begin
				for (i = 0; i < size; i++)
					occ_map[best_start + i] = 1'b1;
				g.base = best_start[ADDR_W-1:0];
				g.hole = best_len[LEN_W-1:0];
			end
		end else if (int'(addr) + int'(size) > MEM_UNITS) begin
			g.status = ST_RESERVE_FAIL;
		end else begin
			clash = 1'b0;
			for (i = 0; i < size; i++)
				if (occ_map[int'(addr) + i])
					clash = 1'b1;
			if (clash) begin
				g.status = ST_RESERVE_FAIL;
			end else begin
				for (i = 0; i < size; i++)
					occ_map[int'(addr) + i] = 1'b1;
				g.base = addr;
			end
		end
		return g;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			bad++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Request side predicts, result side compares with the oldest grant
	always @(posedge clk) begin
		grant_t want;
		logic [STAT_W-1:0] got_status;
		logic [ADDR_W-1:0] got_base;
		logic [LEN_W-1:0]  got_hole;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				grant_q.push_back(place_request(s_axis_tuser, s_axis_tdata[SIZE_W-1:0],
					s_axis_tdata[SIZE_W +: ADDR_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				got_status = m_axis_tdata[STAT_W-1:0];
				got_base   = m_axis_tdata[STAT_W +: ADDR_W];
				got_hole   = m_axis_tdata[STAT_W+ADDR_W +: LEN_W];
				if (grant_q.size() == 0) begin
					bad++;
					$display("%0t: unexpected result, expected none, got status %0d base %0d hole %0d",
						$time, got_status, got_base, got_hole);
				end else begin
					want = grant_q.pop_front();
					compare_field("status", want.status, got_status);
					compare_field("base_address", want.base, got_base);
					compare_field("hole_length", want.hole, got_hole);
				end
			end
			pending <= grant_q.size();
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import wfba_pkg::*;

	localparam int MEM_UNITS     = MEM_UNITS_DEF;
	localparam int RANDOM_ITEMS  = 600;
	localparam int CYCLE_LIMIT   = 10_000_000;
	localparam int DRAIN_CYCLES  = 2000;
	localparam int SINK_HOLD_AT  = 60_000;
	localparam int SINK_HOLD_LEN = 4_000;
	localparam int CALM_FROM     = 150_000;
	localparam int CALM_TO       = 180_000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // req_size, req_address
	logic                   s_axis_tuser = OP_ALLOC;  // op
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // status, base_address, hole_length
	int                     mismatches, pending;
	int                     cycles = 0;
	bit                     tight = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	worst_fit_bitmap_allocator #(.MEM_UNITS(MEM_UNITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	wfba_tb_checker #(.MEM_UNITS(MEM_UNITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.mismatches(mismatches), .pending(pending)
	);

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return $urandom_range(3, 1);
		else if (pick < 95)
			return $urandom_range(24, 4);
		else
			return $urandom_range(150, 40);
	endfunction

	// Offers one request, waits for it to be taken, then maybe idles
	task automatic issue(input logic op, input int size, input int addr);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= IN_TDATA_W'({addr[ADDR_W-1:0], size[SIZE_W-1:0]});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		gap = (tight || $urandom_range(1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: random backpressure, one long hold, one stretch always ready
	initial begin : result_sink
		int ncyc, idle;
		ncyc = 0;
		idle = 0;
		forever begin
			@(posedge clk);
			ncyc++;
			if (ncyc == SINK_HOLD_AT)
				idle = SINK_HOLD_LEN;
			else if (idle == 0 && !(ncyc >= CALM_FROM && ncyc < CALM_TO) &&
					$urandom_range(9) == 0)
				idle = idle_len();
			if (idle > 0) begin
				m_axis_tready <= 1'b0;
				idle--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Request side
	initial begin : request_source
		int   k, pick, size, addr;
		logic op;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ties, edge-of-memory reserves
		issue(OP_ALLOC, 0, 0);         // zero size on an empty map: longest run, nothing marked
		issue(OP_ALLOC, 1023, 0);      // far beyond memory
		issue(OP_ALLOC, 513, 0);       // just beyond memory
		issue(OP_RESERVE, 2, 511);     // runs past the end
		issue(OP_RESERVE, 0, 0);       // zero size reserve
		issue(OP_RESERVE, 0, 511);
		issue(OP_RESERVE, 1, 511);     // last unit
		issue(OP_RESERVE, 1, 255);     // splits the map into two equal holes
		issue(OP_ALLOC, 512, 0);       // no single hole is that long now
		issue(OP_ALLOC, 1, 0);         // tie goes to the lower hole
		issue(OP_ALLOC, 0, 0);
		issue(OP_RESERVE, 1, 0);       // overlap
		issue(OP_RESERVE, 1023, 300);
		issue(OP_RESERVE, 2, 400);
		issue(OP_ALLOC, 3, 0);
		issue(OP_ALLOC, 252, 0);       // one longer than the largest hole
		issue(OP_RESERVE, 1, 128);
		issue(OP_RESERVE, 3, 509);     // fits memory but hits the used last unit
		issue(OP_RESERVE, 1023, 0);
		issue(OP_ALLOC, 2, 0);

		// random: mostly small grants so the map lasts, with some noise
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			tight = (k >= 200 && k < 260);
			if (k == 400) begin
				// let the block drain completely
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			addr = $urandom_range(MEM_UNITS - 1);
			op = OP_RESERVE;
			if (pick < 20) begin
				op = OP_ALLOC;
				size = ($urandom_range(9) < 8) ? 1 : $urandom_range(4, 2);
			end else if (pick < 35) begin
				op = OP_ALLOC;
				size = 0;
			end else if (pick < 38) begin
				op = OP_ALLOC;
				size = $urandom_range(24, 5);
			end else if (pick < 44) begin
				op = OP_ALLOC;
				size = $urandom_range(1023, 512);
			end else if (pick < 70) begin
				size = $urandom_range(3, 0);
			end else if (pick < 76) begin
				size = $urandom_range(16, 4);
			end else if (pick < 95) begin
				// close to the top end of memory
				addr = MEM_UNITS - $urandom_range(8, 1);
				size = $urandom_range(9, 0);
			end else begin
				size = $urandom_range(1023, 0);
			end
			issue(op, size, addr);
		end
		tight = 1'b0;

		// sweep every unit so the map ends up full
		for (k = 0; k < MEM_UNITS; k++)
			issue(OP_RESERVE, 1, k);
		issue(OP_ALLOC, 0, 0);         // zero size on a full map: no-fit
		issue(OP_ALLOC, 1, 0);
		issue(OP_RESERVE, 0, 511);
		issue(OP_RESERVE, 1, 0);
		s_axis_tvalid <= 1'b0;

		// wait for the last results, then a quiet period for strays
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/wfba_pkg.sv
rtl/wfba_bitmap.sv
rtl/wfba_run_tracker.sv
rtl/worst_fit_bitmap_allocator.sv
rtl/wfba_checker.sv
dv/wfba_checker.sv
dv/tb.sv
